[design/pagb_pkg.sv]
package pagb_pkg;

    localparam int IN_W   = 16;
    localparam int STAT_W = 2;
    localparam int NID_W  = 6;

    localparam logic [STAT_W-1:0] ST_ADDED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_COMPLETE = 2'd2;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic init_step;
        logic scan;
        logic link;
        logic fin_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic complete;
        logic hit;
        logic miss_end;
        logic finish;
        logic out_free;
    } t_stat;

endpackage

[design/pagb_draw_if.sv]
interface pagb_draw_if import pagb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] random_draw;

    modport source (output valid, output random_draw, input ready);
    modport sink   (input valid, input random_draw, output ready);
endinterface

[design/pagb_result_if.sv]
interface pagb_result_if import pagb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [NID_W-1:0]  from_node;
    logic [NID_W-1:0]  to_node;
    logic              node_finished;

    modport source (output valid, output status, output from_node, output to_node,
                    output node_finished, input ready);
    modport sink   (input valid, input status, input from_node, input to_node,
                    input node_finished, output ready);
endinterface

[design/preferential_attachment_graph_builder.sv]
// Preferential-attachment graph builder.
// Input channel i_draw carries one random draw per word; output channel
// o_result returns exactly one word per draw: status (edge added, draw
// rejected, graph complete), the chosen earlier node, the node being
// attached and a flag set when that node got its last edge.
// A draw walks the degree memory of the earlier nodes, one entry per cycle
// through a single read port with registered data; a rejected draw scans
// every earlier node, an added edge stops the scan at the found node and
// writes its degree (and the attached node's degree when that node
// finishes), and once the graph is complete the scan is skipped. One item is
// in flight at a time, i_draw.ready is high only while the block waits.
// Reset loads the clique: the degree memory is initialized over the
// first min(CLIQUE, NODES) entries, one per cycle, and no draw is taken
// during that pass. A finished word waits in an output register; when the
// receiver stalls, the next draw is still taken and processed, and its
// result is held until the register frees up.
module preferential_attachment_graph_builder import pagb_pkg::*; #(
    parameter int NODES          = 64,
    parameter int CLIQUE         = 4,
    parameter int EDGES_PER_NODE = 2,
    parameter int DRAW_BITS      = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    pagb_draw_if.sink     i_draw,
    pagb_result_if.source o_result
);

    t_cmd  cmd;
    t_stat stat;

    pagb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_draw.valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pagb_dp #(
        .NODES          (NODES),
        .CLIQUE         (CLIQUE),
        .EDGES_PER_NODE (EDGES_PER_NODE),
        .DRAW_BITS      (DRAW_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_draw          (i_draw.random_draw),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_status        (o_result.status),
        .o_from_node     (o_result.from_node),
        .o_to_node       (o_result.to_node),
        .o_node_finished (o_result.node_finished)
    );

    assign i_draw.ready = cmd.in_ready;

endmodule

[design/pagb_ctrl.sv]
module pagb_ctrl import pagb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_stat.complete ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_LINK;
                end else if (i_stat.miss_end) begin
                    n_state = S_DONE;
                end
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = i_stat.finish ? S_FIN : S_DONE;
            end
            S_FIN: begin
                o_cmd.fin_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/pagb_dp.sv]
module pagb_dp import pagb_pkg::*; #(
    parameter int NODES          = 64,
    parameter int CLIQUE         = 4,
    parameter int EDGES_PER_NODE = 2,
    parameter int DRAW_BITS      = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [IN_W-1:0]   i_draw,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [NID_W-1:0]  o_from_node,
    output logic [NID_W-1:0]  o_to_node,
    output logic              o_node_finished
);

    localparam int CLIQUE_EFF = (CLIQUE < NODES) ? CLIQUE : NODES;
    localparam int NODE_W     = $clog2(NODES);
    localparam int NCW        = $clog2(NODES + 1);
    localparam int DEG_W      = $clog2(NODES);
    localparam int TOT_W      = $clog2(NODES * NODES);
    localparam int EW         = $clog2(EDGES_PER_NODE + 1);
    localparam int THR_W      = DRAW_BITS + TOT_W;

    logic [DEG_W-1:0] r_deg_mem [NODES];
    logic [DEG_W-1:0] r_rd_data;

    logic [TOT_W-1:0]  r_total;
    logic [NCW-1:0]    r_node;
    logic [EW-1:0]     r_edges;
    logic [NODE_W-1:0] r_part [EDGES_PER_NODE];

    logic [THR_W-1:0]  r_thr;
    logic [TOT_W-1:0]  r_sum;
    logic [NCW-1:0]    r_rd_idx;
    logic              r_cmp_vld;
    logic [NODE_W-1:0] r_cmp_idx;
    logic [NODE_W-1:0] r_found;
    logic [DEG_W-1:0]  r_found_deg;

    logic [STAT_W-1:0] r_res_status;
    logic [NCW-1:0]    r_res_to;
    logic              r_res_fin;

    logic              r_out_vld;
    logic [STAT_W-1:0] r_out_status;
    logic [NID_W-1:0]  r_out_from;
    logic [NID_W-1:0]  r_out_to;
    logic              r_out_fin;

    logic              issue;
    logic [TOT_W-1:0]  sum_nx;
    logic              linked;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [DEG_W-1:0]  wr_data;

    assign issue  = i_cmd.scan && (r_rd_idx < r_node);
    assign sum_nx = r_sum + TOT_W'(r_rd_data);

    always_comb begin
        linked = 1'b0;
        for (int k = 0; k < EDGES_PER_NODE; k++) begin
            if ((EW'(k) < r_edges) && (r_part[k] == r_cmp_idx)) begin
                linked = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.init_last = (r_rd_idx == NCW'(CLIQUE_EFF - 1));
        o_stat.complete  = (r_node == NCW'(NODES));
        // running sum passes draw * total when the high part of the product is below it
        o_stat.hit       = i_cmd.scan && r_cmp_vld && !linked
                           && (r_thr[THR_W-1:DRAW_BITS] < sum_nx);
        o_stat.miss_end  = i_cmd.scan && r_cmp_vld && !o_stat.hit
                           && (NCW'(r_cmp_idx) == r_node - NCW'(1));
        o_stat.finish    = (r_edges == EW'(EDGES_PER_NODE - 1));
        o_stat.out_free  = !r_out_vld || i_out_ready;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_found;
        wr_data = r_found_deg + DEG_W'(1);
        if (i_cmd.init_step) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx[NODE_W-1:0];
            wr_data = DEG_W'(CLIQUE_EFF - 1);
        end else if (i_cmd.link) begin
            wr_en = 1'b1;
        end else if (i_cmd.fin_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_node[NODE_W-1:0];
            wr_data = DEG_W'(EDGES_PER_NODE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_deg_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_deg_mem[r_rd_idx[NODE_W-1:0]];
    end

    // graph state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOT_W'(CLIQUE_EFF * (CLIQUE_EFF - 1));
            r_node  <= NCW'(CLIQUE_EFF);
            r_edges <= '0;
        end else begin
            if (i_cmd.link) begin
                r_total <= r_total + TOT_W'(2);
                r_edges <= o_stat.finish ? '0 : r_edges + EW'(1);
            end
            if (i_cmd.fin_wr) begin
                r_node <= r_node + NCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link) begin
            r_part[0] <= r_found;
            for (int k = 1; k < EDGES_PER_NODE; k++) begin
                r_part[k] <= r_part[k-1];
            end
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.init_step) begin
            r_rd_idx <= o_stat.init_last ? '0 : r_rd_idx + NCW'(1);
        end else if (i_cmd.accept) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= issue;
            if (issue) begin
                r_rd_idx <= r_rd_idx + NCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_thr        <= THR_W'(DRAW_BITS'(i_draw)) * THR_W'(r_total);
            r_sum        <= '0;
            r_res_status <= o_stat.complete ? ST_COMPLETE : ST_REJECTED;
            r_res_to     <= o_stat.complete ? '0 : r_node;
            r_res_fin    <= 1'b0;
            r_found      <= '0;
        end else if (i_cmd.scan) begin
            if (r_cmp_vld) begin
                r_sum <= sum_nx;
            end
            if (o_stat.hit) begin
                r_found      <= r_cmp_idx;
                r_found_deg  <= r_rd_data;
                r_res_status <= ST_ADDED;
            end
        end else if (i_cmd.link) begin
            r_res_fin <= o_stat.finish;
        end
        if (issue) begin
            r_cmp_idx <= r_rd_idx[NODE_W-1:0];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_from   <= NID_W'(r_found);
            r_out_to     <= NID_W'(r_res_to);
            r_out_fin    <= r_res_fin;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_from_node     = r_out_from;
    assign o_to_node       = r_out_to;
    assign o_node_finished = r_out_fin;

endmodule

[verif/preferential_attachment_graph_builder_test.sv]
`timescale 1ns / 100ps

module preferential_attachment_graph_builder_test;
    import pagb_pkg::*;

    localparam int NODES          = 64;
    localparam int CLIQUE         = 4;
    localparam int EDGES_PER_NODE = 2;
    localparam int DRAW_BITS      = 16;
    localparam int DRAW_MAX       = (1 << DRAW_BITS) - 1;
    localparam int REJECT_BUDGET  = 1680;
    localparam int TAIL_CYCLES    = NODES + 16;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NID_W-1:0]  from_node;
        logic [NID_W-1:0]  to_node;
        logic              node_finished;
    } t_link_word;

    class t_graph_tracker;
        bit [6:0]       degree [NODES];
        bit [NODES-1:0] linked [NODES];
        bit [11:0]      total;
        bit [6:0]       current;
        bit [2:0]       quota_used;
        t_link_word     expected_links [$];
        int             mismatches;

        function new();
            for (int a = 0; a < CLIQUE && a < NODES; a++)
                for (int b = a + 1; b < CLIQUE && b < NODES; b++)
                    connect(a, b);
            current    = 7'((CLIQUE < NODES) ? CLIQUE : NODES);
            quota_used = '0;
            mismatches = 0;
        endfunction

        function void connect(int a, int b);
            linked[a][b] = 1'b1;
            linked[b][a] = 1'b1;
            degree[a]++;
            degree[b]++;
            total += 12'd2;
        endfunction

        function bit done();
            return current >= NODES;
        endfunction

        function int pending();
            return expected_links.size();
        endfunction

        // Smallest draw that the current node would reject; above DRAW_MAX when none.
        function int reject_floor();
            longint unsigned prefix;
            longint unsigned last_prefix;
            bit              found;
            prefix      = 0;
            last_prefix = 0;
            found       = 1'b0;
            if (done())
                return DRAW_MAX + 1;
            for (int j = 0; j < current; j++) begin
                prefix += longint'(degree[j]);
                if (!linked[j][current]) begin
                    last_prefix = prefix;
                    found       = 1'b1;
                end
            end
            if (!found)
                return 0;
            return int'(((last_prefix << DRAW_BITS) + longint'(total) - 64'd1)
                        / longint'(total));
        endfunction

        function void take_draw(bit [DRAW_BITS-1:0] draw);
            t_link_word      w;
            longint unsigned threshold;
            longint unsigned prefix;
            int              pick;
            w      = '0;
            pick   = -1;
            prefix = 0;
            if (done()) begin
                w.status = ST_COMPLETE;
            end else begin
                threshold = longint'(draw) * longint'(total);
                for (int j = 0; j < current; j++) begin
                    prefix += longint'(degree[j]);
                    if (threshold < (prefix << DRAW_BITS) && !linked[j][current]) begin
                        pick = j;
                        break;
                    end
                end
                w.to_node = current[NID_W-1:0];
                if (pick < 0) begin
                    w.status = ST_REJECTED;
                end else begin
                    connect(pick, int'(current));
                    w.status    = ST_ADDED;
                    w.from_node = pick[NID_W-1:0];
                    quota_used++;
                    if (quota_used >= EDGES_PER_NODE) begin
                        w.node_finished = 1'b1;
                        quota_used      = '0;
                        current++;
                    end
                end
            end
            expected_links = {expected_links, w};
        endfunction

        function void match_result(t_link_word got);
            t_link_word want;
            if (expected_links.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected word status %0d from %0d to %0d fin %0d",
                             got.status, got.from_node, got.to_node, got.node_finished);
                return;
            end
            want = expected_links.pop_front();
            if (got.status !== want.status || got.from_node !== want.from_node ||
                got.to_node !== want.to_node || got.node_finished !== want.node_finished) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                             want.status, want.from_node, want.to_node, want.node_finished,
                             got.status, got.from_node, got.to_node, got.node_finished);
            end
        endfunction
    endclass

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            feed_valid = 1'b0;
    logic [IN_W-1:0] feed_draw  = '0;
    logic            take_ready = 1'b0;
    bit              idle_on    = 1'b1;
    bit              stall_on   = 1'b1;
    int              stall_left = 0;
    longint          cycles     = 0;
    t_graph_tracker  tracker    = new();

    bit [IN_W-1:0] corner_draws [14] = '{
        16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000,
        16'h7FFF, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE, 16'h00FF, 16'hFF00
    };

    pagb_draw_if   draw_bus ();
    pagb_result_if result_bus ();

    assign draw_bus.valid       = feed_valid;
    assign draw_bus.random_draw = feed_draw;
    assign result_bus.ready     = take_ready;

    preferential_attachment_graph_builder #(
        .NODES          (NODES),
        .CLIQUE         (CLIQUE),
        .EDGES_PER_NODE (EDGES_PER_NODE),
        .DRAW_BITS      (DRAW_BITS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_draw   (draw_bus),
        .o_result (result_bus)
    );

    always #2 i_clk = ~i_clk;

    // stall the result channel in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            take_ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            take_ready <= 1'b0;
        end else begin
            take_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (i_rst_n && result_bus.valid && result_bus.ready) begin
            tracker.match_result({result_bus.status, result_bus.from_node,
                                  result_bus.to_node, result_bus.node_finished});
        end
    end

    task feed(input logic [IN_W-1:0] d);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            feed_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        feed_valid <= 1'b1;
        feed_draw  <= d;
        do @(posedge i_clk); while (!draw_bus.ready);
        tracker.take_draw(d);
    endtask

    // hold the draw channel until every word has come back
    task settle();
        feed_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    initial begin
        int            sent;
        int            floor_d;
        logic [IN_W-1:0] d;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corner_draws[k])
            feed(corner_draws[k]);
        settle();
        sent = $size(corner_draws);

        // steer most draws into the current node's reject window while the reject budget lasts
        while (!tracker.done()) begin
            if (sent % 64 == 0) begin
                idle_on  = ($urandom_range(0, 2) != 0);
                stall_on = ($urandom_range(0, 2) != 0);
            end
            floor_d = tracker.reject_floor();
            if (sent < REJECT_BUDGET && floor_d <= DRAW_MAX && $urandom_range(0, 199) < 193)
                d = IN_W'($urandom_range(DRAW_MAX, floor_d));
            else
                d = IN_W'($urandom);
            feed(d);
            sent++;
            if ($urandom_range(0, 299) == 0)
                settle();
        end

        idle_on  = 1'b0;
        stall_on = 1'b0;
        feed(16'h0000);
        feed(16'hFFFF);
        repeat (24) feed(IN_W'($urandom));
        feed_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
